// ===== rtl/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// shared types, constants and the symbol table of the base64 stream encoder
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam logic [7:0] PAD_CHAR        = 8'd61;
    localparam logic [7:0] NEWLINE_CHAR    = 8'd10;
    localparam logic [4:0] GROUPS_PER_LINE = 5'd19;

    // what kind of group a job carries
    typedef enum logic [1:0] {
        KIND_FULL = 2'd0,   // three bytes, four symbols
        KIND_ONE  = 2'd1,   // one byte, two symbols and two pads
        KIND_TWO  = 2'd2    // two bytes, three symbols and one pad
    } kind_t;

    // one unit of work from the front end to the back end
    typedef struct packed {
        logic [23:0] bits;
        kind_t       kind;
        logic        newline;
        logic        last;
    } job_t;

    // job queue status seen by the other parts
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // standard alphabet lookup
    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = 8'd65 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            c = 8'd71 + {2'b00, v};
        end
        else if (v < 6'd62)
        begin
            c = {2'b00, v} - 8'd4;
        end
        else if (v == 6'd62)
        begin
            c = 8'd43;
        end
        else
        begin
            c = 8'd47;
        end
        return c;
    endfunction

endpackage

// ===== rtl/base64_stream_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// streaming base64 encoder, one byte in, one ascii character out per beat
// path: a byte ending a group goes via the job queue, job and output registers
// throughput: one character a cycle, set by the single output register,
//   when popped, so a byte stream is taken at three bytes per four characters
// reset: async active low, clears pending bytes, group count, queue and output
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    // input side, looks like a queue
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       is_final,
    // output side, looks like a queue
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       out_last,
    // split_lines register
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import b64enc_pkg::*;

    logic      in_beat;
    logic      job_push;
    logic      job_pop;
    job_t      front_job;
    job_t      queue_job;
    q_status_t q_status;

    // an input beat is taken only while the job queue has room
    assign full    = q_status.full;
    assign in_beat = push && !full;

    // front end: groups bytes, line count, builds jobs
    b64enc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_beat),
        .data_byte (data_byte),
        .is_final  (is_final),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job_push  (job_push),
        .job       (front_job)
    );

    // short queue so each side stalls on its own
    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_job (front_job),
        .pop    (job_pop),
        .rd_job (queue_job),
        .status (q_status)
    );

    // back end: serialises characters into the output register
    b64enc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_job    (queue_job),
        .q_status (q_status),
        .q_pop    (job_pop),
        .pop      (pop),
        .empty    (empty),
        .out_char (out_char),
        .out_last (out_last)
    );

    // a final byte always leaves a job waiting in the queue
    a_final_queued : assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && is_final |=> !q_status.empty)
        else $error("final byte did not produce a job");

    // padding characters come back to back until the last one
    a_pad_chain : assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && out_char == PAD_CHAR && !out_last
        |=> !empty && out_char == PAD_CHAR)
        else $error("broken padding run");

    // a newline only closes a full group, so it never follows padding
    a_nl_after_pad : assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && out_char == PAD_CHAR |=> empty || out_char != NEWLINE_CHAR)
        else $error("newline after padding");

endmodule

// ===== rtl/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// gathers bytes into groups, counts groups per line and issues jobs
// ----------------------------------------------------------------------------
module b64enc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               is_final,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output logic               job_push,
    output b64enc_pkg::job_t   job
);
    import b64enc_pkg::*;

    logic [15:0] pend_reg,  pend_next;
    logic [1:0]  cnt_reg,   cnt_next;
    logic [4:0]  gol_reg,   gol_next;
    logic        split_reg, split_next;
    logic [4:0]  gol_inc;
    logic        wrap;

    assign gol_inc = gol_reg + 5'd1;
    assign wrap    = (gol_inc == GROUPS_PER_LINE);

    always_comb
    begin
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        gol_next    = gol_reg;
        split_next  = cfg_we ? cfg_wdata : split_reg;
        job_push    = 1'b0;
        job.bits    = {pend_reg, data_byte};
        job.kind    = KIND_FULL;
        job.newline = 1'b0;
        job.last    = is_final;
        if (accept)
        begin
            unique case (cnt_reg)
                2'd2, 2'd3:
                begin
                    // group complete
                    job_push    = 1'b1;
                    job.newline = wrap & split_reg;
                    cnt_next    = 2'd0;
                    gol_next    = wrap ? 5'd0 : gol_inc;
                end
                2'd1:
                begin
                    pend_next = {pend_reg[15:8], data_byte};
                    cnt_next  = 2'd2;
                    job.kind  = KIND_TWO;
                    job.bits  = {pend_reg[15:8], data_byte, 8'h00};
                    job_push  = is_final;
                end
                default:
                begin
                    pend_next = {data_byte, 8'h00};
                    cnt_next  = 2'd1;
                    job.kind  = KIND_ONE;
                    job.bits  = {data_byte, 16'h0000};
                    job_push  = is_final;
                end
            endcase
            if (is_final)
            begin
                pend_next = 16'h0000;
                cnt_next  = 2'd0;
                gol_next  = 5'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            cnt_reg   <= '0;
            gol_reg   <= '0;
            split_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            gol_reg   <= gol_next;
            split_reg <= split_next;
        end
    end

endmodule

// ===== rtl/b64enc_queue.sv =====
// ----------------------------------------------------------------------------
// b64enc_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
module b64enc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64enc_pkg::job_t      wr_job,
    input  logic                  pop,
    output b64enc_pkg::job_t      rd_job,
    output b64enc_pkg::q_status_t status
);
    import b64enc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg,    cnt_next;

    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);
    assign rd_job       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// turns one job into its characters, one a cycle while the output register is free or popped, into the output register
// ----------------------------------------------------------------------------
module b64enc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64enc_pkg::job_t      q_job,
    input  b64enc_pkg::q_status_t q_status,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic [7:0]            out_char,
    output logic                  out_last
);
    import b64enc_pkg::*;

    job_t       job_reg,       job_next;
    logic       job_valid_reg, job_valid_next;
    logic [2:0] idx_reg,       idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg,  out_char_next;
    logic       out_last_reg,  out_last_next;

    logic       beat_out;
    logic       emit;
    logic       job_end;
    logic [2:0] final_idx;
    logic [5:0] sym_val;
    logic       is_pad;
    logic [7:0] cur_char;

    assign beat_out  = pop && out_valid_reg;
    assign emit      = job_valid_reg && (!out_valid_reg || beat_out);
    assign final_idx = (job_reg.kind == KIND_FULL && job_reg.newline) ? 3'd4 : 3'd3;
    assign job_end   = emit && (idx_reg == final_idx);
    assign q_pop     = !q_status.empty && (!job_valid_reg || job_end);

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    sym_val = job_reg.bits[23:18];
            3'd1:    sym_val = job_reg.bits[17:12];
            3'd2:    sym_val = job_reg.bits[11:6];
            default: sym_val = job_reg.bits[5:0];
        endcase
        unique case (job_reg.kind)
            KIND_ONE: is_pad = (idx_reg >= 3'd2);
            KIND_TWO: is_pad = (idx_reg == 3'd3);
            default:  is_pad = 1'b0;
        endcase
        priority if (idx_reg == 3'd4)
        begin
            cur_char = NEWLINE_CHAR;
        end
        else if (is_pad)
        begin
            cur_char = PAD_CHAR;
        end
        else
        begin
            cur_char = sym_char(sym_val);
        end
    end

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (q_pop)
        begin
            job_next       = q_job;
            job_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
        else if (job_end)
        begin
            job_valid_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 3'd1;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = cur_char;
            out_last_next  = job_reg.last && (idx_reg == final_idx);
        end
        else if (beat_out)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_char = out_char_reg;
    assign out_last = out_last_reg;

endmodule
